// ===== hw/rtl/dlfc_pkg.sv =====
// Shared types, codes and reset values for the dual-link failover controller.
`timescale 1ns / 1ps

package dlfc_pkg;

    // Link selector codes
    typedef logic [1:0] link_t;
    localparam link_t LINK_NONE = 2'd0;
    localparam link_t LINK_WIFI = 2'd1;
    localparam link_t LINK_CELL = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_WIFI_ENABLED    = 3'd0;
    localparam cfg_idx_t CFG_CELL_ENABLED    = 3'd1;
    localparam cfg_idx_t CFG_CHECK_PERIOD_MS = 3'd2;
    localparam cfg_idx_t CFG_TRY_DURATION_MS = 3'd3;
    localparam cfg_idx_t CFG_WIFI_FAIL_LIMIT = 3'd4;
    localparam cfg_idx_t CFG_CELL_FAIL_LIMIT = 3'd5;

    // Field widths and bus widths
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 8;
    localparam int S_TDATA_W  = 40;  // 34 bits of fields, padded to 5 bytes
    localparam int M_TDATA_W  = 24;  // 21 bits of fields, padded to 3 bytes
    localparam int CFG_DATA_W = 32;

    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam count_t COUNT_MAX = 8'hFF;

    // Register reset values
    localparam time_t  RST_CHECK_PERIOD_MS = 32'd600000;
    localparam time_t  RST_TRY_DURATION_MS = 32'd300000;
    localparam count_t RST_WIFI_FAIL_LIMIT = 8'd50;
    localparam count_t RST_CELL_FAIL_LIMIT = 8'd1;

    // One poll as held in the input register
    typedef struct packed {
        logic  cell_ok;
        logic  wifi_ok;
        time_t now_ms;
    } poll_t;

    // One result as held in the output register
    typedef struct packed {
        count_t cell_failures;
        count_t wifi_failures;
        logic   drop_wifi;
        logic   switched;
        link_t  link;
        logic   active;
    } result_t;

endpackage

// ===== hw/rtl/dual_link_failover_controller_core.sv =====
// Top level of the dual-link failover controller: poll pipeline, state and config registers.
`timescale 1ns / 1ps

// Dual-link (Wi-Fi / cellular) failover controller. Each request on the
// s_ stream is one poll: a millisecond timestamp plus a health bit per link.
// A poll is active once more than check_period_ms has gone by (mod 2^32)
// since the last try-window close; the first active poll opens a window and
// an active poll more than try_duration_ms past the window start closes it.
// Active polls run link selection: a single enabled link is forced, with both
// enabled the block fails over to cellular once the Wi-Fi failure count
// exceeds wifi_fail_limit (pulsing drop_wifi), and back to Wi-Fi when the
// cellular count before its increment exceeds cell_fail_limit. Every poll
// yields exactly one result on the m_ stream. A poll goes through the input
// register, then a single combinational pass into the result register that
// also updates the state, and one poll is accepted every clock while
// m_tready is high; a stalled result holds the pipe with no loss. The config
// port is always ready; write it only while no poll is in flight. Writes to
// indexes beyond the register list are ignored.
module dual_link_failover_controller_core (
    input  logic                          aclk,
    input  logic                          aresetn,

    // Poll requests
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] now_ms, [32] wifi_ok, [33] cell_ok, [39:34] zero
    input  logic [dlfc_pkg::S_TDATA_W-1:0] s_tdata,

    // Results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] active, [2:1] link, [3] switched, [4] drop_wifi,
    // [12:5] wifi_failures, [20:13] cell_failures, [23:21] zero
    output logic [dlfc_pkg::M_TDATA_W-1:0] m_tdata,

    // Configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dlfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dlfc_pkg::CFG_DATA_W-1:0] cfg_data
);

    // ---------------- configuration registers ----------------
    logic                   wifi_enabled_reg;
    logic                   cell_enabled_reg;
    dlfc_pkg::time_t        check_period_reg;
    dlfc_pkg::time_t        try_duration_reg;
    dlfc_pkg::count_t       wifi_limit_reg;
    dlfc_pkg::count_t       cell_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wifi_enabled_reg <= 1'b1;
            cell_enabled_reg <= 1'b1;
            check_period_reg <= dlfc_pkg::RST_CHECK_PERIOD_MS;
            try_duration_reg <= dlfc_pkg::RST_TRY_DURATION_MS;
            wifi_limit_reg   <= dlfc_pkg::RST_WIFI_FAIL_LIMIT;
            cell_limit_reg   <= dlfc_pkg::RST_CELL_FAIL_LIMIT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dlfc_pkg::CFG_WIFI_ENABLED:    wifi_enabled_reg <= cfg_data[0];
                dlfc_pkg::CFG_CELL_ENABLED:    cell_enabled_reg <= cfg_data[0];
                dlfc_pkg::CFG_CHECK_PERIOD_MS: check_period_reg <= cfg_data;
                dlfc_pkg::CFG_TRY_DURATION_MS: try_duration_reg <= cfg_data;
                dlfc_pkg::CFG_WIFI_FAIL_LIMIT:
                    wifi_limit_reg <= cfg_data[dlfc_pkg::COUNT_W-1:0];
                dlfc_pkg::CFG_CELL_FAIL_LIMIT:
                    cell_limit_reg <= cfg_data[dlfc_pkg::COUNT_W-1:0];
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic              in_valid_reg;
    dlfc_pkg::poll_t   in_poll_reg;
    logic              out_valid_reg;
    dlfc_pkg::result_t out_res_reg;
    logic              advance;   // stage 1 moves into the result register

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_poll_reg <= s_tdata[$bits(dlfc_pkg::poll_t)-1:0];
        end
    end

    // ---------------- controller state ----------------
    dlfc_pkg::time_t  last_close_reg,   last_close_next;
    dlfc_pkg::time_t  win_start_reg,    win_start_next;
    logic             win_open_reg,     win_open_next;
    dlfc_pkg::link_t  sel_link_reg,     sel_link_next;
    dlfc_pkg::count_t wifi_fail_reg,    wifi_fail_next;
    dlfc_pkg::count_t cell_fail_reg,    cell_fail_next;
    dlfc_pkg::result_t res_next;

    dlfc_pkg::time_t  since_close;
    dlfc_pkg::time_t  since_start;
    logic             poll_active;
    dlfc_pkg::count_t wifi_inc;
    dlfc_pkg::count_t cell_inc;
    logic             sw;
    logic             drop;

    always_comb begin
        since_close = in_poll_reg.now_ms - last_close_reg;
        poll_active = since_close > check_period_reg;

        wifi_inc = (wifi_fail_reg == dlfc_pkg::COUNT_MAX) ? dlfc_pkg::COUNT_MAX
                                                         : wifi_fail_reg + 8'd1;
        cell_inc = (cell_fail_reg == dlfc_pkg::COUNT_MAX) ? dlfc_pkg::COUNT_MAX
                                                         : cell_fail_reg + 8'd1;

        last_close_next = last_close_reg;
        win_start_next  = win_start_reg;
        win_open_next   = win_open_reg;
        sel_link_next   = sel_link_reg;
        wifi_fail_next  = wifi_fail_reg;
        cell_fail_next  = cell_fail_reg;
        sw              = 1'b0;
        drop            = 1'b0;

        if (poll_active) begin
            // the first active poll opens the window at its own timestamp
            if (!win_open_reg) begin
                win_start_next = in_poll_reg.now_ms;
                win_open_next  = 1'b1;
            end

            priority if (wifi_enabled_reg && cell_enabled_reg) begin
                if (sel_link_reg == dlfc_pkg::LINK_WIFI) begin
                    if (!in_poll_reg.wifi_ok) begin
                        // count after increment is checked
                        if (wifi_inc > wifi_limit_reg) begin
                            wifi_fail_next = '0;
                            sel_link_next  = dlfc_pkg::LINK_CELL;
                            sw             = 1'b1;
                            drop           = 1'b1;
                        end else begin
                            wifi_fail_next = wifi_inc;
                        end
                    end else begin
                        wifi_fail_next = '0;
                    end
                end else if (sel_link_reg == dlfc_pkg::LINK_CELL) begin
                    if (!in_poll_reg.cell_ok) begin
                        // count before increment is checked
                        if (cell_fail_reg > cell_limit_reg) begin
                            cell_fail_next = '0;
                            sel_link_next  = dlfc_pkg::LINK_WIFI;
                            sw             = 1'b1;
                        end else begin
                            cell_fail_next = cell_inc;
                        end
                    end
                end
            end else if (wifi_enabled_reg) begin
                sel_link_next = dlfc_pkg::LINK_WIFI;
            end else if (cell_enabled_reg) begin
                sel_link_next = dlfc_pkg::LINK_CELL;
            end else begin
                sel_link_next = sel_link_reg;
            end

            since_start = in_poll_reg.now_ms - win_start_next;
            if (since_start > try_duration_reg) begin
                last_close_next = in_poll_reg.now_ms;
                win_open_next   = 1'b0;
            end
        end else begin
            since_start = '0;
        end

        res_next.active        = poll_active;
        res_next.link          = sel_link_next;
        res_next.switched      = sw;
        res_next.drop_wifi     = drop;
        res_next.wifi_failures = wifi_fail_next;
        res_next.cell_failures = cell_fail_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_close_reg <= '0;
            win_start_reg  <= '0;
            win_open_reg   <= 1'b0;
            sel_link_reg   <= dlfc_pkg::LINK_WIFI;
            wifi_fail_reg  <= '0;
            cell_fail_reg  <= '0;
        end else if (advance) begin
            last_close_reg <= last_close_next;
            win_start_reg  <= win_start_next;
            win_open_reg   <= win_open_next;
            sel_link_reg   <= sel_link_next;
            wifi_fail_reg  <= wifi_fail_next;
            cell_fail_reg  <= cell_fail_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(dlfc_pkg::M_TDATA_W - $bits(dlfc_pkg::result_t)){1'b0}}, out_res_reg};

endmodule
